[rtl/lrz_pkg.sv]
// ----------------------------------------------------------------------------
// lrz_pkg
// shared types, constants and saturation helper for the lorenz-96 integrator
// ----------------------------------------------------------------------------
package lrz_pkg;

  localparam int VAL_W  = 32;   // q12.20 state word
  localparam int SUM_W  = 36;   // k1 + 2k2 + 2k3 + k4
  localparam int DT_W   = 21;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 6;
  localparam int WIDE_W = 66;   // working width for sums before saturation
  localparam int QUO_W  = 38;   // rounded update magnitude before divide by 6
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] REG_FORCING    = 2'd1;
  localparam logic [1:0] REG_STEP_COUNT = 2'd2;

  // one ring position
  typedef struct packed {
    logic signed [VAL_W-1:0] base;
    logic signed [VAL_W-1:0] stage;
    logic signed [VAL_W-1:0] nstage;
    logic signed [SUM_W-1:0] sum;
  } cell_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic rotate;
    logic load;
    logic copy;
    logic commit;
    logic wr_stage;
    logic wr_base;
  } cell_ctl_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh7FFF_FFFF);
    lo = -WIDE_W'(64'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

[rtl/lrz_cell.sv]
// ----------------------------------------------------------------------------
// lrz_cell
// one ring position: base, stage, next stage and slope sum; rotates with ring
// ----------------------------------------------------------------------------
module lrz_cell
  import lrz_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl_i,
  input  logic      load_sel_i,
  input  logic      tgt_sel_i,
  input  cell_t     nbr_i,
  input  cell_t     wd_i,
  output cell_t     cell_o
);

  cell_t cell_r;

  always_ff @(posedge clk) begin
    priority if (ctl_i.rotate) begin
      cell_r <= nbr_i;
    end else if (ctl_i.load && load_sel_i) begin
      cell_r.base <= wd_i.base;
    end else if (ctl_i.copy) begin
      cell_r.stage <= cell_r.base;
    end else if (ctl_i.commit) begin
      cell_r.stage <= cell_r.nstage;
    end else if (ctl_i.wr_stage && tgt_sel_i) begin
      cell_r.nstage <= wd_i.nstage;
      cell_r.sum    <= wd_i.sum;
    end else if (ctl_i.wr_base && tgt_sel_i) begin
      cell_r.base <= wd_i.base;
    end
  end

  assign cell_o = cell_r;

endmodule

[rtl/lrz_div6.sv]
// ----------------------------------------------------------------------------
// lrz_div6
// divide by six, one quotient byte per cycle by reciprocal multiply
// ----------------------------------------------------------------------------
module lrz_div6
  import lrz_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [QUO_W-1:0] dvd_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  localparam int DIG_W = 8;
  localparam int NDIG  = (QUO_W + DIG_W - 1) / DIG_W;
  localparam int SHR_W = NDIG * DIG_W;
  localparam int TRL_W = DIG_W + 3;
  localparam int RCP_W = TRL_W + 9;
  // floor(t * 683 / 4096) equals floor(t / 6) for every t below 6 * 256
  localparam logic [RCP_W-1:0] RECIP_6 = RCP_W'(683);

  logic [SHR_W-1:0] dvd_r;
  logic [2:0]       rem_r;
  logic [2:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [TRL_W-1:0] trial;
  logic [RCP_W-1:0] rcp;
  logic [DIG_W-1:0] qdig;
  logic [TRL_W-1:0] qx6;

  // remainder below six on top of the next dividend byte
  assign trial = {rem_r, dvd_r[SHR_W-1 -: DIG_W]};
  assign rcp   = RCP_W'(trial) * RECIP_6;
  assign qdig  = rcp[RCP_W-1:12];
  assign qx6   = (TRL_W'(qdig) << 1) + (TRL_W'(qdig) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 3'(NDIG);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 3'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= SHR_W'(dvd_i);
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SHR_W-DIG_W-1:0], qdig};
      rem_r <= 3'(trial - qx6);
    end
  end

  assign quo_o  = dvd_r[QUO_W-1:0];
  assign done_o = done_r;

endmodule

[rtl/lorenz96_rk4_integrator.sv]
// ----------------------------------------------------------------------------
// lorenz96_rk4_integrator
// lorenz-96 ring integrator, classic fourth-order runge-kutta in q12.20
// ----------------------------------------------------------------------------
// usage: stream n state values (1..RING_SIZE) into in_*, the last one with
// in_tlast (a full ring ends the load by itself). in_tready stays high for the
// whole load. the block then runs step_count rk4 steps and streams the n
// results out with their index, out_tlast on the last. input is not taken
// while a batch integrates or drains. in one rk4 step every slope passes a
// six-state walk through the shared multiply path, and the final update of
// each element waits on a divide by six that retires one quotient byte per
// cycle. the state lives in a ring of cells that rotates one place per
// element, so the shared unit always sees its four neighbors at fixed taps.
// registers: 0x0 step_size, 0x4 forcing, 0x8 step_count; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module lorenz96_rk4_integrator
  import lrz_pkg::*;
#(
  parameter int RING_SIZE = 40
)
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // [31:0] state_value
  input  logic              in_tlast,    // last_in
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,   // [31:0] result_value, [37:32] result_index
  output logic              out_tlast,   // last_out
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam int CW = $clog2(RING_SIZE + 1);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_COPY  = 15'b000000000000010,
    ST_TAPS  = 15'b000000000000100,
    ST_MUL   = 15'b000000000001000,
    ST_SLOPE = 15'b000000000010000,
    ST_DT    = 15'b000000000100000,
    ST_UPD   = 15'b000000001000000,
    ST_ROT   = 15'b000000010000000,
    ST_ADV   = 15'b000000100000000,
    ST_FMUL  = 15'b000001000000000,
    ST_FRND  = 15'b000010000000000,
    ST_FDIV  = 15'b000100000000000,
    ST_FWR   = 15'b001000000000000,
    ST_FROT  = 15'b010000000000000,
    ST_EMIT  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [DT_W-1:0]         dt_r;
  logic signed [VAL_W-1:0] forcing_r;
  logic [CNT_W-1:0]        count_r;
  logic                    cfg_wr;

  // sequencing
  logic [CW-1:0]    load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    elem_r, elem_nxt;
  logic [1:0]       rk_r, rk_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             last_elem;

  // arithmetic pipeline registers
  logic signed [VAL_W-1:0]  d_r, xm1_r, xi_r, base_t_r, k_r;
  logic signed [SUM_W-1:0]  sum_t_r, sum_new_r;
  logic signed [63:0]       prod_r;
  logic signed [53:0]       m_r;
  logic signed [57:0]       p_r;
  logic                     neg_r;

  // ring
  cell_t     cell_q [RING_SIZE];
  cell_t     nbr    [RING_SIZE];
  cell_t     wd;
  cell_ctl_t ctl;
  logic      small_ring;

  logic signed [VAL_W-1:0] tap0, tap1, tap2, tap3, base_live;
  logic signed [SUM_W-1:0] sum_live;

  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r      <= DT_W'(5243);
      forcing_r <= 32'sd8388608;
      count_r   <= CNT_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_STEP_SIZE:  dt_r      <= cfg_pwdata[DT_W-1:0];
        REG_FORCING:    forcing_r <= cfg_pwdata;
        REG_STEP_COUNT: count_r   <= cfg_pwdata[CNT_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_STEP_SIZE:  cfg_prdata = 32'(dt_r);
      REG_FORCING:    cfg_prdata = forcing_r;
      REG_STEP_COUNT: cfg_prdata = 32'(count_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // ring of cells; cell j takes from j+1, the last live cell wraps to cell 0
  // ------------------------------------------------------------------------
  // for rings below three elements the element under work sits in cell 0
  assign small_ring = (n_r < CW'(3));

  for (genvar j = 0; j < RING_SIZE; j++) begin : g_cell
    assign nbr[j] = (CW'(j + 1) == n_r) ? cell_q[0] : cell_q[(j + 1) % RING_SIZE];

    lrz_cell u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .load_sel_i (load_cnt_r[IW-1:0] == IW'(j)),
      .tgt_sel_i  ((j == 0 && small_ring) || (j == 2 && !small_ring)),
      .nbr_i      (nbr[j]),
      .wd_i       (wd),
      .cell_o     (cell_q[j])
    );
  end

  // neighbor taps x[i-2], x[i-1], x[i], x[i+1], wrapped for tiny rings
  always_comb begin
    tap0 = cell_q[0].stage;
    tap1 = (n_r == CW'(1)) ? cell_q[0].stage : cell_q[1].stage;
    tap2 = small_ring ? cell_q[0].stage : cell_q[2].stage;
    if (n_r == CW'(1)) begin
      tap3 = cell_q[0].stage;
    end else if (n_r == CW'(2)) begin
      tap3 = cell_q[1].stage;
    end else if (n_r == CW'(3)) begin
      tap3 = cell_q[0].stage;
    end else begin
      tap3 = cell_q[3].stage;
    end
  end

  assign base_live = small_ring ? cell_q[0].base : cell_q[2].base;
  assign sum_live  = small_ring ? cell_q[0].sum  : cell_q[2].sum;

  // ------------------------------------------------------------------------
  // shared slope / update datapath
  // ------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] prod_rnd, stage_inc, upd_q;
  logic signed [SUM_W-1:0]  k_ext;
  logic [57:0]              p_mag;

  assign prod_rnd  = (WIDE_W'(prod_r) + WIDE_W'(64'sd524288)) >>> 20;
  assign k_ext     = SUM_W'(k_r);
  // half steps shift by 21, the full step by 20
  assign stage_inc = (rk_r == 2'd2) ?
                     ((WIDE_W'(m_r) + WIDE_W'(64'sd524288)) >>> 20) :
                     ((WIDE_W'(m_r) + WIDE_W'(64'sd1048576)) >>> 21);
  assign p_mag     = p_r[57] ? 58'(-p_r) : 58'(p_r);
  assign upd_q     = neg_r ? -$signed({28'b0, div_quo}) : $signed({28'b0, div_quo});

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_TAPS: begin
        d_r      <= sat32(WIDE_W'(tap3) - WIDE_W'(tap0));
        xm1_r    <= tap1;
        xi_r     <= tap2;
        base_t_r <= base_live;
        sum_t_r  <= sum_live;
      end
      ST_MUL:   prod_r <= xm1_r * d_r;
      ST_SLOPE: k_r <= sat32(prod_rnd - WIDE_W'(xi_r) + WIDE_W'(forcing_r));
      ST_DT: begin
        m_r <= $signed({1'b0, dt_r}) * k_r;
        unique case (rk_r)
          2'd0:       sum_new_r <= k_ext;
          2'd1, 2'd2: sum_new_r <= sum_t_r + (k_ext <<< 1);
          default:    sum_new_r <= sum_t_r + k_ext;
        endcase
      end
      ST_FMUL: begin
        p_r      <= $signed({1'b0, dt_r}) * sum_live;
        base_t_r <= base_live;
      end
      ST_FRND: begin
        // ties away from zero: round magnitude, then divide by six
        neg_r <= p_r[57];
      end
      default: ;
    endcase
  end

  lrz_div6 u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (state_r == ST_FRND),
    .dvd_i   (QUO_W'((p_mag + 58'd3145728) >> 20)),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // cell write data
  always_comb begin
    wd        = '0;
    wd.nstage = sat32(WIDE_W'(base_t_r) + stage_inc);
    wd.sum    = sum_new_r;
    if (state_r == ST_IDLE) begin
      wd.base = in_tdata;
    end else begin
      wd.base = sat32(WIDE_W'(base_t_r) + upd_q);
    end
  end

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  assign last_elem = (elem_r + 1'b1 == n_r);

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    elem_nxt     = elem_r;
    rk_nxt       = rk_r;
    steps_nxt    = steps_r;
    ctl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.load     = 1'b1;
          load_cnt_nxt = load_cnt_r + 1'b1;
          if (in_tlast || (load_cnt_r + 1'b1 == CW'(RING_SIZE))) begin
            n_nxt        = load_cnt_r + 1'b1;
            load_cnt_nxt = '0;
            elem_nxt     = '0;
            steps_nxt    = '0;
            state_nxt    = (count_r == '0) ? ST_EMIT : ST_COPY;
          end
        end
      end
      ST_COPY: begin
        ctl.copy  = 1'b1;
        rk_nxt    = '0;
        elem_nxt  = '0;
        state_nxt = ST_TAPS;
      end
      ST_TAPS:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SLOPE;
      ST_SLOPE: state_nxt = ST_DT;
      ST_DT:    state_nxt = ST_UPD;
      ST_UPD: begin
        ctl.wr_stage = 1'b1;
        state_nxt    = ST_ROT;
      end
      ST_ROT: begin
        ctl.rotate = 1'b1;
        if (last_elem) begin
          elem_nxt  = '0;
          state_nxt = (rk_r == 2'd3) ? ST_FMUL : ST_ADV;
        end else begin
          elem_nxt  = elem_r + 1'b1;
          state_nxt = ST_TAPS;
        end
      end
      ST_ADV: begin
        ctl.commit = 1'b1;
        rk_nxt     = rk_r + 1'b1;
        state_nxt  = ST_TAPS;
      end
      ST_FMUL: state_nxt = ST_FRND;
      ST_FRND: state_nxt = ST_FDIV;
      ST_FDIV: begin
        if (div_done) begin
          state_nxt = ST_FWR;
        end
      end
      ST_FWR: begin
        ctl.wr_base = 1'b1;
        state_nxt   = ST_FROT;
      end
      ST_FROT: begin
        ctl.rotate = 1'b1;
        if (last_elem) begin
          elem_nxt = '0;
          if (steps_r + 1'b1 == count_r) begin
            steps_nxt = '0;
            state_nxt = ST_EMIT;
          end else begin
            steps_nxt = steps_r + 1'b1;
            state_nxt = ST_COPY;
          end
        end else begin
          elem_nxt  = elem_r + 1'b1;
          state_nxt = ST_FMUL;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          ctl.rotate = 1'b1;
          if (last_elem) begin
            elem_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            elem_nxt = elem_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      n_r        <= CW'(1);
      elem_r     <= '0;
      rk_r       <= '0;
      steps_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      n_r        <= n_nxt;
      elem_r     <= elem_nxt;
      rk_r       <= rk_nxt;
      steps_r    <= steps_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // stream ports; results come straight from cell 0 as the ring rotates
  // ------------------------------------------------------------------------
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {2'b00, IDX_W'(elem_r), cell_q[0].base};
  assign out_tlast  = last_elem;

endmodule
